FILE: hw/rtl/xmov_pkg.sv
// ----------------------------------------------------------------------------
// xmov_pkg
// Types, opcode constants and record builders shared by the MOV decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xmov_pkg;

   // opcode match patterns
   localparam logic [7:0] IMM_MASK  = 8'hF0;
   localparam logic [7:0] IMM_OPC   = 8'hB0;
   localparam logic [7:0] RM_MASK   = 8'hFC;
   localparam logic [7:0] RM_OPC    = 8'h88;
   localparam logic [2:0] DIRECT_RM = 3'd6;

   // mod field codes
   localparam logic [1:0] MOD_NO_DISP   = 2'd0;
   localparam logic [1:0] MOD_BYTE_DISP = 2'd1;
   localparam logic [1:0] MOD_WORD_DISP = 2'd2;
   localparam logic [1:0] MOD_REGISTER  = 2'd3;

   // instruction lengths
   localparam logic [2:0] LEN_ONE   = 3'd1;
   localparam logic [2:0] LEN_TWO   = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR  = 3'd4;

   // position within the current instruction
   typedef enum logic [1:0] {
      PH_OPCODE = 2'd0,
      PH_BYTE1  = 2'd1,
      PH_BYTE2  = 2'd2,
      PH_BYTE3  = 2'd3
   } phase_type;

   // record kinds
   typedef enum logic [1:0] {
      KIND_IMM     = 2'd0,
      KIND_RM      = 2'd1,
      KIND_UNKNOWN = 2'd2
   } kind_type;

   // one decoded instruction record
   typedef struct packed {
      kind_type    kind;
      logic        is_word;
      logic        to_register;
      logic [3:0]  reg_code;
      logic [1:0]  addr_mode;
      logic [3:0]  rm_code;
      logic        direct_address;
      logic [15:0] displacement;
      logic [15:0] immediate;
      logic [2:0]  instr_length;
   } rec_type;

   // decoder controls for the holding registers
   typedef struct packed {
      logic load_opcode;
      logic load_modrm;
      logic load_low;
      logic emit;
   } ctl_type;

   function automatic logic [15:0] sext8(input logic [7:0] b);
      return {{8{b[7]}}, b};
   endfunction

   function automatic logic is_imm_op(input logic [7:0] op);
      return (op & IMM_MASK) == IMM_OPC;
   endfunction

   function automatic logic is_rm_op(input logic [7:0] op);
      return (op & RM_MASK) == RM_OPC;
   endfunction

   function automatic rec_type make_imm(input logic [7:0] op, input logic [15:0] imm,
                                        input logic [2:0] len);
      rec_type r;
      r              = '0;
      r.kind         = KIND_IMM;
      r.is_word      = op[3];
      r.to_register  = 1'b1;
      r.reg_code     = {op[3], op[2:0]};
      r.immediate    = imm;
      r.instr_length = len;
      return r;
   endfunction

   function automatic rec_type make_rm(input logic [7:0] op, input logic [7:0] modrm,
                                       input logic [15:0] disp, input logic [2:0] len);
      rec_type r;
      r                = '0;
      r.kind           = KIND_RM;
      r.is_word        = op[0];
      r.to_register    = op[1];
      r.reg_code       = {op[0], modrm[5:3]};
      r.addr_mode      = modrm[7:6];
      r.rm_code        = {(modrm[7:6] == MOD_REGISTER) & op[0], modrm[2:0]};
      r.direct_address = (modrm[7:6] == MOD_NO_DISP) && (modrm[2:0] == DIRECT_RM);
      r.displacement   = disp;
      r.instr_length   = len;
      return r;
   endfunction

   function automatic rec_type make_unknown();
      rec_type r;
      r              = '0;
      r.kind         = KIND_UNKNOWN;
      r.instr_length = LEN_ONE;
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/xmov_decode.sv
// ----------------------------------------------------------------------------
// xmov_decode
// Per-byte decode: next phase, holding register loads and the record.
// ----------------------------------------------------------------------------
`default_nettype none

module xmov_decode
   import xmov_pkg::*;
(
   input  wire logic [7:0] code_byte,
   input  wire phase_type  phase,
   input  wire logic [7:0] held_opcode,
   input  wire logic [7:0] held_modrm,
   input  wire logic [7:0] held_low,
   output phase_type       phase_next,
   output ctl_type         ctl,
   output rec_type         rec
);

   logic       imm;
   logic [1:0] byte_mod;
   logic [2:0] byte_rm;
   logic       modrm_done;
   logic [7:0] modrm_eff;

   // shared field views
   assign imm        = is_imm_op(held_opcode);
   assign byte_mod   = code_byte[7:6];
   assign byte_rm    = code_byte[2:0];
   assign modrm_done = (byte_mod == MOD_REGISTER) ||
                       ((byte_mod == MOD_NO_DISP) && (byte_rm != DIRECT_RM));
   assign modrm_eff  = (phase == PH_BYTE1) ? code_byte : held_modrm;

   // next phase
   always_comb begin
      phase_next = PH_OPCODE;
      case (phase)
         PH_BYTE1: begin
            if (imm) begin
               phase_next = held_opcode[3] ? PH_BYTE2 : PH_OPCODE;
            end else begin
               phase_next = modrm_done ? PH_OPCODE : PH_BYTE2;
            end
         end
         PH_BYTE2: begin
            if (!imm && (held_modrm[7:6] != MOD_BYTE_DISP)) begin
               phase_next = PH_BYTE3;
            end
         end
         PH_BYTE3: begin
            if (imm && (is_imm_op(code_byte) || is_rm_op(code_byte))) begin
               phase_next = PH_BYTE1;
            end
         end
         default: begin
            if (is_imm_op(code_byte) || is_rm_op(code_byte)) begin
               phase_next = PH_BYTE1;
            end
         end
      endcase
   end

   // register loads and record
   always_comb begin
      ctl = '0;
      rec = make_unknown();
      case (phase)
         PH_BYTE1: begin
            if (imm) begin
               ctl.emit     = !held_opcode[3];
               ctl.load_low = held_opcode[3];
               rec          = make_imm(held_opcode, sext8(code_byte), LEN_TWO);
            end else begin
               ctl.load_modrm = 1'b1;
               ctl.emit       = modrm_done;
               rec            = make_rm(held_opcode, modrm_eff, '0, LEN_TWO);
            end
         end
         PH_BYTE2: begin
            if (imm) begin
               ctl.emit = 1'b1;
               rec      = make_imm(held_opcode, {code_byte, held_low}, LEN_THREE);
            end else if (held_modrm[7:6] == MOD_BYTE_DISP) begin
               ctl.emit = 1'b1;
               rec      = make_rm(held_opcode, modrm_eff, sext8(code_byte), LEN_THREE);
            end else begin
               ctl.load_low = 1'b1;
            end
         end
         PH_BYTE3: begin
            if (!imm) begin
               ctl.emit = 1'b1;
               rec      = make_rm(held_opcode, modrm_eff, {code_byte, held_low}, LEN_FOUR);
            end else begin
               // stray phase: byte taken as an opcode
               ctl.load_opcode = 1'b1;
               ctl.emit        = !(is_imm_op(code_byte) || is_rm_op(code_byte));
            end
         end
         default: begin
            ctl.load_opcode = 1'b1;
            ctl.emit        = !(is_imm_op(code_byte) || is_rm_op(code_byte));
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/x86_mov_decoder_top.sv
// Path: an accepted byte is held in the input register and decoded there; a record
// it completes is written to the result register and driven on rsp_.
// Throughput: one byte per cycle unless rsp_stall holds a result, set by the single
// decode stage between the input register and the result register.
// Reset: synchronous, clears both valids, the phase and the held bytes.
// ----------------------------------------------------------------------------
// x86_mov_decoder_top
// Byte-stream decoder for 8086 MOV immediate and reg/mem forms.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_mov_decoder_top
   import xmov_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_code_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_instr_kind,
   output logic             rsp_is_word,
   output logic             rsp_to_register,
   output logic [3:0]       rsp_reg_code,
   output logic [1:0]       rsp_addr_mode,
   output logic [3:0]       rsp_rm_code,
   output logic             rsp_direct_address,
   output logic [15:0]      rsp_displacement,
   output logic [15:0]      rsp_immediate,
   output logic [2:0]       rsp_instr_length
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   phase_type  phase_ff;
   phase_type  phase_in;
   logic [7:0] opcode_ff;
   logic [7:0] modrm_ff;
   logic [7:0] low_ff;
   logic       out_valid_ff;
   rec_type    out_rec_ff;
   ctl_type    ctl;
   rec_type    rec;
   logic       advance;
   logic       in_load;

   // stage handshakes
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!in_valid_ff || advance) begin
         in_valid_ff <= req_valid;
      end
      if (in_load) begin
         in_byte_ff <= req_code_byte;
      end
   end

   xmov_decode u_decode (
      .code_byte   (in_byte_ff),
      .phase       (phase_ff),
      .held_opcode (opcode_ff),
      .held_modrm  (modrm_ff),
      .held_low    (low_ff),
      .phase_next  (phase_in),
      .ctl         (ctl),
      .rec         (rec)
   );

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         opcode_ff <= '0;
         modrm_ff  <= '0;
         low_ff    <= '0;
      end else if (in_valid_ff && advance) begin
         phase_ff <= phase_in;
         if (ctl.load_opcode) begin
            opcode_ff <= in_byte_ff;
         end
         if (ctl.load_modrm) begin
            modrm_ff <= in_byte_ff;
         end
         if (ctl.load_low) begin
            low_ff <= in_byte_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff && ctl.emit;
      end
      if (advance && in_valid_ff && ctl.emit) begin
         out_rec_ff <= rec;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_instr_kind     = out_rec_ff.kind;
   assign rsp_is_word        = out_rec_ff.is_word;
   assign rsp_to_register    = out_rec_ff.to_register;
   assign rsp_reg_code       = out_rec_ff.reg_code;
   assign rsp_addr_mode      = out_rec_ff.addr_mode;
   assign rsp_rm_code        = out_rec_ff.rm_code;
   assign rsp_direct_address = out_rec_ff.direct_address;
   assign rsp_displacement   = out_rec_ff.displacement;
   assign rsp_immediate      = out_rec_ff.immediate;
   assign rsp_instr_length   = out_rec_ff.instr_length;

endmodule

`default_nettype wire

FILE: hw/rtl/xmov_checker.sv
// ----------------------------------------------------------------------------
// xmov_checker
// Port-level checks on the decoder's result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module xmov_checker
   import xmov_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_instr_kind,
   input wire logic        rsp_is_word,
   input wire logic        rsp_to_register,
   input wire logic [3:0]  rsp_reg_code,
   input wire logic [1:0]  rsp_addr_mode,
   input wire logic [3:0]  rsp_rm_code,
   input wire logic        rsp_direct_address,
   input wire logic [15:0] rsp_displacement,
   input wire logic [15:0] rsp_immediate,
   input wire logic [2:0]  rsp_instr_length
);

   // a stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_instr_kind) &&
         $stable(rsp_reg_code) && $stable(rsp_displacement) &&
         $stable(rsp_immediate) && $stable(rsp_instr_length))
      else $error("stalled result beat changed");

   // unknown byte record is bare
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_instr_kind == KIND_UNKNOWN) |->
         (rsp_instr_length == LEN_ONE) && !rsp_is_word && !rsp_to_register &&
         (rsp_reg_code == '0) && (rsp_displacement == '0) && (rsp_immediate == '0))
      else $error("unknown record has stray fields");

   // immediate record shape
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_instr_kind == KIND_IMM) |->
         rsp_to_register && (rsp_addr_mode == '0) && (rsp_rm_code == '0) &&
         !rsp_direct_address && (rsp_displacement == '0) &&
         (rsp_reg_code[3] == rsp_is_word) &&
         ((rsp_instr_length == LEN_TWO) || (rsp_instr_length == LEN_THREE)))
      else $error("bad immediate record");

   // reg/mem record shape
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_instr_kind == KIND_RM) |->
         (rsp_immediate == '0) && (rsp_reg_code[3] == rsp_is_word) &&
         (rsp_direct_address == ((rsp_addr_mode == MOD_NO_DISP) &&
                                 (rsp_rm_code == {1'b0, DIRECT_RM}))) &&
         ((rsp_instr_length == LEN_TWO) || (rsp_instr_length == LEN_THREE) ||
          (rsp_instr_length == LEN_FOUR)))
      else $error("bad reg/mem record");

   // no reserved kind code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_instr_kind == KIND_IMM) || (rsp_instr_kind == KIND_RM) ||
         (rsp_instr_kind == KIND_UNKNOWN))
      else $error("reserved record kind");

endmodule

bind x86_mov_decoder_top xmov_checker u_xmov_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_instr_kind     (rsp_instr_kind),
   .rsp_is_word        (rsp_is_word),
   .rsp_to_register    (rsp_to_register),
   .rsp_reg_code       (rsp_reg_code),
   .rsp_addr_mode      (rsp_addr_mode),
   .rsp_rm_code        (rsp_rm_code),
   .rsp_direct_address (rsp_direct_address),
   .rsp_displacement   (rsp_displacement),
   .rsp_immediate      (rsp_immediate),
   .rsp_instr_length   (rsp_instr_length)
);

`default_nettype wire
